>>> rtl/core/rau_pkg.sv
// Shared types, widths and codes of the rational arithmetic unit.
package rau_pkg;

    // Operand and datapath widths.
    localparam int OPERAND_WIDTH = 16;
    localparam int DEN_WIDTH     = OPERAND_WIDTH - 1;
    localparam int MUL_WIDTH     = OPERAND_WIDTH + 1;
    localparam int PROD_WIDTH    = 2 * MUL_WIDTH;
    localparam int NUM_WIDTH     = 2 * OPERAND_WIDTH;
    localparam int MAG_WIDTH     = NUM_WIDTH;
    localparam int SUB_WIDTH     = MAG_WIDTH + 1;
    localparam int CNT_WIDTH     = $clog2(MAG_WIDTH);
    localparam int RES_NUM_WIDTH = 32;
    localparam int RES_DEN_WIDTH = 31;
    localparam int EXT_WIDTH     = (NUM_WIDTH > RES_NUM_WIDTH) ? NUM_WIDTH : RES_NUM_WIDTH;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // Result status codes.
    typedef enum logic {
        ST_OK       = 1'b0,
        ST_DIV_ZERO = 1'b1
    } t_status;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_PREP,
        S_SIGN,
        S_ABS,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_DONE
    } t_rau_state;

    // One input item.
    typedef struct packed {
        t_op                             req_type;
        logic signed [OPERAND_WIDTH-1:0] a_num;
        logic        [DEN_WIDTH-1:0]     a_den;
        logic signed [OPERAND_WIDTH-1:0] b_num;
        logic        [DEN_WIDTH-1:0]     b_den;
    } t_rau_in;

    // One result item.
    typedef struct packed {
        logic signed [RES_NUM_WIDTH-1:0] res_num;
        logic        [RES_DEN_WIDTH-1:0] res_den;
        t_status                         status;
    } t_rau_out;

endpackage

>>> rtl/core/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: sequencer, multiplier and reduction datapath.
//
// The unit takes one operation on two fractions at a time and returns the result in lowest
// terms. An item passes through the multiplier states MUL0, MUL1 and MUL2, the states that form
// and normalize the raw fraction, a binary GCD loop of one step per cycle (fewer steps for small
// values), two restoring divisions by the GCD, and the hand-over of the result to the output
// register. A divide by zero skips the reduction. The GCD loop and the divisions all run
// through one shared subtractor, and the three cross products go through one multiplier.
// The input stalls while an item is in work; a finished result waits in the output register
// and does not hold back the next input transfer.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_rau_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_rau_out o_out_data
);

    t_rau_state r_state, n_state;

    // Captured operands.
    t_op                             r_op;
    logic signed [OPERAND_WIDTH-1:0] r_an, r_bn;
    logic        [DEN_WIDTH-1:0]     r_ad, r_bd;

    // Products and raw fraction.
    logic signed [NUM_WIDTH-1:0] r_p1, r_p2, r_p3;
    logic signed [NUM_WIDTH-1:0] r_num, r_den;
    logic                        r_err, r_neg;

    // Reduction state.
    logic [MAG_WIDTH-1:0] r_mag, r_dmag, r_ga, r_gb, r_g;
    logic [CNT_WIDTH-1:0] r_k, r_cnt;
    logic [SUB_WIDTH-1:0] r_rem;
    logic [MAG_WIDTH-1:0] r_quo, r_qn, r_qd;

    // Output register.
    logic     r_out_valid;
    t_rau_out r_out_data;

    // Combinational signals.
    logic signed [MUL_WIDTH-1:0]  s_mul_a, s_mul_b, s_ad_ext, s_bd_ext;
    logic signed [PROD_WIDTH-1:0] s_prod;
    logic [SUB_WIDTH-1:0]         s_sub_x, s_sub_y, s_sub_diff, s_shift;
    logic                         s_sub_ge;
    logic [MAG_WIDTH-1:0]         s_quo_next;
    logic                         s_div_last;
    logic                         s_out_free, s_out_load, s_in_stall;
    logic signed [NUM_WIDTH-1:0]  s_num_signed;
    logic signed [EXT_WIDTH-1:0]  s_num_ext;
    logic        [EXT_WIDTH-1:0]  s_den_ext;

    // Denominators as non-negative multiplier operands.
    assign s_ad_ext = {2'b00, r_ad};
    assign s_bd_ext = {2'b00, r_bd};

    // The single multiplier.
    assign s_prod = s_mul_a * s_mul_b;

    // The shared subtractor.
    rau_sub_unit u_sub (
        .i_x    (s_sub_x),
        .i_y    (s_sub_y),
        .o_diff (s_sub_diff),
        .o_ge   (s_sub_ge)
    );

    // Restoring division step: shift the next dividend bit into the remainder.
    assign s_shift    = {r_rem[MAG_WIDTH-1:0], r_quo[MAG_WIDTH-1]};
    assign s_quo_next = {r_quo[MAG_WIDTH-2:0], s_sub_ge};
    assign s_div_last = (r_cnt == CNT_WIDTH'(MAG_WIDTH - 1));

    // The output register can take a result when it is empty or being drained.
    assign s_out_free = ~r_out_valid | ~i_out_stall;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_MUL0;
            end
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_PREP;
            S_PREP: n_state = S_SIGN;
            S_SIGN: begin
                n_state = (r_den == '0) ? S_DONE : S_ABS;
            end
            S_ABS:  n_state = S_GCD;
            S_GCD: begin
                if (r_ga == '0) n_state = S_DIVN;
            end
            S_DIVN: begin
                if (s_div_last) n_state = S_DIVD;
            end
            S_DIVD: begin
                if (s_div_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (s_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: stall, multiplier operands, subtractor operands, result load.
    always_comb begin
        s_in_stall = (r_state != S_IDLE);
        s_mul_a    = '0;
        s_mul_b    = '0;
        s_sub_x    = '0;
        s_sub_y    = '0;
        s_out_load = 1'b0;
        case (r_state)
            S_MUL0: begin
                s_mul_a = MUL_WIDTH'(r_an);
                s_mul_b = (r_op == OP_MUL) ? MUL_WIDTH'(r_bn) : s_bd_ext;
            end
            S_MUL1: begin
                s_mul_a = MUL_WIDTH'(r_bn);
                s_mul_b = s_ad_ext;
            end
            S_MUL2: begin
                s_mul_a = s_ad_ext;
                s_mul_b = (r_op == OP_DIV) ? MUL_WIDTH'(r_bn) : s_bd_ext;
            end
            S_GCD: begin
                s_sub_x = {1'b0, r_ga};
                s_sub_y = {1'b0, r_gb};
            end
            S_DIVN, S_DIVD: begin
                s_sub_x = s_shift;
                s_sub_y = {1'b0, r_g};
            end
            S_DONE: begin
                s_out_load = s_out_free;
            end
            default: begin
                s_out_load = 1'b0;
            end
        endcase
    end

    assign o_in_stall = s_in_stall;

    // Datapath registers, stepped by the sequencer state.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_op <= i_in_data.req_type;
                    r_an <= i_in_data.a_num;
                    r_ad <= i_in_data.a_den;
                    r_bn <= i_in_data.b_num;
                    r_bd <= i_in_data.b_den;
                end
            end
            S_MUL0: r_p1 <= NUM_WIDTH'(s_prod);
            S_MUL1: r_p2 <= NUM_WIDTH'(s_prod);
            S_MUL2: r_p3 <= NUM_WIDTH'(s_prod);
            S_PREP: begin
                case (r_op)
                    OP_ADD:  r_num <= r_p1 + r_p2;
                    OP_SUB:  r_num <= r_p1 - r_p2;
                    default: r_num <= r_p1;
                endcase
                r_den <= r_p3;
            end
            S_SIGN: begin
                // A negative denominator hands its sign to the numerator.
                r_err <= (r_den == '0);
                if (r_den[NUM_WIDTH-1]) begin
                    r_num <= -r_num;
                    r_den <= -r_den;
                end
            end
            S_ABS: begin
                r_neg  <= r_num[NUM_WIDTH-1];
                r_mag  <= r_num[NUM_WIDTH-1] ? MAG_WIDTH'(-r_num) : MAG_WIDTH'(r_num);
                r_ga   <= r_num[NUM_WIDTH-1] ? MAG_WIDTH'(-r_num) : MAG_WIDTH'(r_num);
                r_dmag <= MAG_WIDTH'(r_den);
                r_gb   <= MAG_WIDTH'(r_den);
                r_k    <= '0;
            end
            S_GCD: begin
                // Binary GCD: strip common twos, then odd-odd subtract or swap.
                if (r_ga == '0) begin
                    r_g   <= r_gb << r_k;
                    r_rem <= '0;
                    r_quo <= r_mag;
                    r_cnt <= '0;
                end else if (!r_ga[0] && !r_gb[0]) begin
                    r_ga <= r_ga >> 1;
                    r_gb <= r_gb >> 1;
                    r_k  <= r_k + 1'b1;
                end else if (!r_ga[0]) begin
                    r_ga <= r_ga >> 1;
                end else if (!r_gb[0]) begin
                    r_gb <= r_gb >> 1;
                end else if (s_sub_ge) begin
                    r_ga <= s_sub_diff[MAG_WIDTH:1];
                end else begin
                    r_ga <= r_gb;
                    r_gb <= r_ga;
                end
            end
            S_DIVN, S_DIVD: begin
                if (s_div_last) begin
                    r_cnt <= '0;
                    if (r_state == S_DIVN) begin
                        // Numerator done; load the denominator for the second division.
                        r_qn  <= s_quo_next;
                        r_rem <= '0;
                        r_quo <= r_dmag;
                    end else begin
                        r_qd <= s_quo_next;
                    end
                end else begin
                    r_rem <= s_sub_ge ? s_sub_diff : s_shift;
                    r_quo <= s_quo_next;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // Reapply the sign and fit the reduced values to the result widths.
    assign s_num_signed = r_neg ? -$signed(r_qn) : $signed(r_qn);
    assign s_num_ext    = EXT_WIDTH'(s_num_signed);
    assign s_den_ext    = EXT_WIDTH'(r_qd);

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (s_out_load) begin
            if (r_err) begin
                r_out_data.res_num <= '0;
                r_out_data.res_den <= '0;
                r_out_data.status  <= ST_DIV_ZERO;
            end else begin
                r_out_data.res_num <= s_num_ext[RES_NUM_WIDTH-1:0];
                r_out_data.res_den <= s_den_ext[RES_DEN_WIDTH-1:0];
                r_out_data.status  <= ST_OK;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // An input transfer always starts the multiplier sequence.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_MUL0))
        else $error("input transfer did not start the multiplier sequence");

    // The GCD loop never runs with a zero second operand.
    a_gcd_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GCD) |-> (r_gb != '0))
        else $error("GCD operand b reached zero");

    // The divisions never see a zero divisor.
    a_div_g: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVN || r_state == S_DIVD) |-> (r_g != '0))
        else $error("division by a zero GCD");

    // A good result carries a nonzero denominator.
    a_ok_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_OK) |-> (o_out_data.res_den != '0))
        else $error("ok result with zero denominator");

    // An error result carries zero fields.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_DIV_ZERO) |->
        (o_out_data.res_num == '0 && o_out_data.res_den == '0))
        else $error("error result with nonzero fields");

endmodule

>>> rtl/core/rau_sub_unit.sv
// Shared subtract and compare unit used by the GCD loop and the divisions.
module rau_sub_unit
    import rau_pkg::*;
(
    input  logic [SUB_WIDTH-1:0] i_x,
    input  logic [SUB_WIDTH-1:0] i_y,
    output logic [SUB_WIDTH-1:0] o_diff,
    output logic                 o_ge
);

    logic [SUB_WIDTH:0] s_full;

    // One extra bit catches the borrow, which tells whether x is below y.
    assign s_full = {1'b0, i_x} - {1'b0, i_y};
    assign o_diff = s_full[SUB_WIDTH-1:0];
    assign o_ge   = ~s_full[SUB_WIDTH];

endmodule
